// File: src/ttrc_pkg.sv
// ----------------------------------------------------------------------------
// ttrc_pkg
// Shared types and constants for the three-term recurrence checksum.
// ----------------------------------------------------------------------------
package ttrc_pkg;

  // One message byte with its framing marks.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } item_t;

  // Width of the product of the widened byte sum and a recurrence term.
  localparam int PROD_W = 25;

  // Offset added to the first byte of a message.
  localparam logic [15:0] FIRST_OFFSET = 16'd7;

  // Multipliers of the position for the two coefficients.
  localparam logic [7:0] ALPHA_MULT = 8'd17;
  localparam logic [7:0] BETA_MULT  = 8'd31;

  // The term modulus, 2^16 - 1.
  localparam logic [15:0] TERM_MOD = 16'hFFFF;

  // A 64-bit wrap of a negative difference adds 2^64, which is 1 modulo
  // the term modulus. Adding 256 moduli on top keeps the value positive.
  localparam logic [PROD_W-1:0] WRAP_BIAS = PROD_W'(256 * 65535 + 1);

  // Reset values of the state.
  localparam logic [15:0] TERM_RESET = 16'd1;
  localparam logic [7:0]  POS_RESET  = 8'd0;

endpackage

// File: src/three_term_recurrence_checksum.sv
// ----------------------------------------------------------------------------
// three_term_recurrence_checksum
// Byte-stream checksum built on a three-term recurrence modulo 2^16 - 1.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one message byte per beat with first and last
// marks. A beat marked first restarts the recurrence; a beat marked last
// produces one checksum beat on the output channel, and other beats
// produce nothing. Both channels use valid and stall.
// A byte is captured in the input register, and from there the recurrence
// update (two narrow multiplies, a subtract and an end-around fold) runs
// and, for a last byte, writes the result register. Throughput is one byte
// per cycle while no last byte waits on a stalled output, set by the
// update loop through the term registers.
// When the receiver stalls, the checksum stays in the result register and
// bytes without the last mark still flow; a last byte waits in the input
// register, and only then is the input stalled.
// Synchronous reset empties both registers and sets the older and newer
// terms to one and the position to zero.
// ----------------------------------------------------------------------------
module three_term_recurrence_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_check_value
);
  import ttrc_pkg::*;

  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        advance;
  logic        out_free;
  logic [15:0] term_nxt;

  assign in_item.data_byte  = in_data_byte;
  assign in_item.first_byte = in_first_byte;
  assign in_item.last_byte  = in_last_byte;

  // A byte moves on unless it needs the result register and that holds a stalled beat.
  assign advance = item_valid && (!item.last_byte || out_free);

  ttrc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ttrc_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (item),
    .term_nxt (term_nxt)
  );

  ttrc_out_reg u_out_reg (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance && item.last_byte),
    .load_value      (term_nxt),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_check_value (out_check_value)
  );

endmodule

// File: src/ttrc_in_reg.sv
// ----------------------------------------------------------------------------
// ttrc_in_reg
// Input register stage: captures one beat and holds it until it advances.
// ----------------------------------------------------------------------------
module ttrc_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ttrc_pkg::item_t in_item,
  input  logic           advance,
  output logic           item_valid,
  output ttrc_pkg::item_t item
);
  import ttrc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  // The stage takes a beat when it is empty or its item moves on.
  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: src/ttrc_step.sv
// ----------------------------------------------------------------------------
// ttrc_step
// Recurrence state and the update of the two terms.
// ----------------------------------------------------------------------------
module ttrc_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  ttrc_pkg::item_t item,
  output logic [15:0]     term_nxt
);
  import ttrc_pkg::*;

  logic [15:0]       older_r;
  logic [15:0]       older_nxt;
  logic [15:0]       newer_r;
  logic [15:0]       newer_nxt;
  logic [7:0]        pos_r;
  logic [7:0]        pos_nxt;
  logic [7:0]        alpha;
  logic [7:0]        beta;
  logic [8:0]        sum_a;
  logic [PROD_W-1:0] prod_p;
  logic [PROD_W-1:0] prod_q;
  logic              p_below_q;
  logic [PROD_W-1:0] diff_x;
  logic [16:0]       fold1;
  logic [15:0]       fold2;
  logic [15:0]       fresh;

  // Coefficients from the position; both wrap at 8 bits.
  assign alpha = 8'(pos_r * ALPHA_MULT);
  assign beta  = 8'(pos_r * BETA_MULT);
  assign sum_a = {1'b0, item.data_byte} + {1'b0, alpha};

  // The two products.
  assign prod_p = PROD_W'(sum_a) * PROD_W'(newer_r);
  assign prod_q = PROD_W'(beta) * PROD_W'(older_r);

  // Difference, with the 64-bit wrap folded into a positive bias.
  assign p_below_q = prod_q > prod_p;
  assign diff_x    = p_below_q ? (prod_p + WRAP_BIAS - prod_q) : (prod_p - prod_q);

  // End-around fold modulo 2^16 - 1.
  assign fold1 = 17'(diff_x[PROD_W-1:16]) + 17'(diff_x[15:0]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign fresh = (fold2 == TERM_MOD) ? 16'd0 : fold2;

  // Next state: a first byte restarts the recurrence.
  always_comb begin
    if (item.first_byte) begin
      older_nxt = TERM_RESET;
      newer_nxt = 16'(item.data_byte) + FIRST_OFFSET;
      pos_nxt   = 8'd1;
    end else begin
      older_nxt = newer_r;
      newer_nxt = fresh;
      pos_nxt   = pos_r + 8'd1;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= TERM_RESET;
      newer_r <= TERM_RESET;
      pos_r   <= POS_RESET;
    end else if (advance) begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign term_nxt = newer_nxt;

endmodule

// File: src/ttrc_out_reg.sv
// ----------------------------------------------------------------------------
// ttrc_out_reg
// Result register: holds a checksum until the receiver takes the beat.
// ----------------------------------------------------------------------------
module ttrc_out_reg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  logic [15:0] load_value,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_check_value
);
  logic        valid_r;
  logic        valid_nxt;
  logic [15:0] value_r;

  // The register can take a new result when empty or being drained.
  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (free ? 1'b0 : valid_r);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= load_value;
    end
  end

  assign out_valid       = valid_r;
  assign out_check_value = value_r;

endmodule

// File: src/ttrc_checker.sv
// ----------------------------------------------------------------------------
// ttrc_checker
// Port-level checks of the checksum block, bound to the top level.
// ----------------------------------------------------------------------------
module ttrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_check_value
);

  // A stalled checksum beat stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_check_value))
    else $error("checksum beat changed while stalled");

  // The checksum is a residue modulo 2^16 - 1, so the all-ones code never shows.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_check_value != 16'hFFFF)
    else $error("checksum outside its residue range");

  // With the result register empty, the input side never stalls.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result waiting");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

endmodule

bind three_term_recurrence_checksum ttrc_checker u_ttrc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_check_value (out_check_value)
);
